[rtl/core/bpbcd_pkg.sv]
// Package for the binary to packed-decimal converter.
// Holds widths, nibble codes, the job and queue status types and the BCD adjust function.
// No dependencies.
package bpbcd_pkg;

   localparam int MAX_FIELD_BYTES_DEF = 16;
   localparam int VALUE_W             = 32;
   localparam int LEN_W               = 5;
   localparam int BYTE_W              = 8;
   localparam int NIB_W               = 4;
   localparam int BCD_DIGITS          = 10;
   localparam int BCD_W               = BCD_DIGITS * NIB_W;
   localparam int STREAM_W            = BCD_W + 2 * NIB_W;
   localparam int STEP_W              = $clog2(VALUE_W);
   localparam int ND_W                = $clog2(BCD_DIGITS + 1);
   localparam int MIN_NEG_BYTES       = 6;
   localparam int QUEUE_DEPTH         = 2;

   localparam logic [NIB_W-1:0]   NIB_NEG   = 4'hB;
   localparam logic [NIB_W-1:0]   NIB_POS   = 4'hC;
   localparam logic [NIB_W-1:0]   NIB_FILL  = 4'hF;
   localparam logic [BYTE_W-1:0]  ZERO_BYTE = 8'hC0;
   localparam logic [BYTE_W-1:0]  PAD_BYTE  = 8'hFF;
   localparam logic [VALUE_W-1:0] MIN_NEG   = 32'h8000_0000;

   typedef enum logic [1:0] {
      KIND_FAIL,
      KIND_ZERO,
      KIND_CONV
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic               neg;
      logic [VALUE_W-1:0] mag;
      logic [LEN_W-1:0]   len;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_NORM,
      ST_EMIT,
      ST_FAIL
   } back_state_type;

   // Adds three to every digit of five or more, ahead of the next shift.
   function automatic logic [BCD_W-1:0] dabble_adjust(input logic [BCD_W-1:0] bcd);
      logic [BCD_W-1:0] res;
      res = bcd;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (bcd[NIB_W*i +: NIB_W] >= 4'd5) begin
            res[NIB_W*i +: NIB_W] = bcd[NIB_W*i +: NIB_W] + 4'd3;
         end
      end
      return res;
   endfunction

endpackage

[rtl/core/bpbcd_if.sv]
// Channel interfaces of the converter: request and response, valid/ready.
// Depends on bpbcd_pkg.
interface bpbcd_req_if;
   import bpbcd_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value;
   logic [LEN_W-1:0]          field_length;
   modport source (output valid, output value, output field_length, input ready);
   modport sink (input valid, input value, input field_length, output ready);
endinterface

interface bpbcd_rsp_if;
   import bpbcd_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              byte_valid;
   logic              last;
   logic              ok;
   modport source (output valid, output out_byte, output byte_valid, output last, output ok,
                   input ready);
   modport sink (input valid, input out_byte, input byte_valid, input last, input ok,
                 output ready);
endinterface

[rtl/core/bpbcd_front.sv]
// Front end: accepts request beats, classifies them and takes the magnitude.
// Depends on bpbcd_pkg and bpbcd_if.
module bpbcd_front #(
   parameter int MAX_FIELD_BYTES = bpbcd_pkg::MAX_FIELD_BYTES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   bpbcd_req_if.sink                    req,
   input  bpbcd_pkg::queue_status_type  q_status,
   output logic                         push,
   output bpbcd_pkg::job_type           push_job
);
   import bpbcd_pkg::*;

   logic               valid_ff, valid_in;
   job_type            job_ff, job_in;
   logic               accept;
   logic [VALUE_W-1:0] value_u;
   logic               bad_len;

   assign value_u   = req.value;
   assign push      = valid_ff && !q_status.full;
   assign req.ready = !valid_ff || !q_status.full;
   assign accept    = req.valid && req.ready;
   assign push_job  = job_ff;

   assign bad_len = (req.field_length == '0) || (int'(req.field_length) > MAX_FIELD_BYTES) ||
                    ((value_u == MIN_NEG) && (req.field_length < LEN_W'(MIN_NEG_BYTES)));

   always_comb begin
      valid_in = valid_ff;
      job_in   = job_ff;
      if (push) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in   = 1'b1;
         job_in.len = req.field_length;
         job_in.neg = value_u[VALUE_W-1];
         job_in.mag = value_u[VALUE_W-1] ? (~value_u + VALUE_W'(1)) : value_u;
         if (bad_len) begin
            job_in.kind = KIND_FAIL;
         end else if (value_u == '0) begin
            job_in.kind = KIND_ZERO;
         end else begin
            job_in.kind = KIND_CONV;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      job_ff <= job_in;
   end

endmodule

[rtl/core/bpbcd_queue.sv]
// Short job queue between the front end and the back end.
// Depends on bpbcd_pkg.
module bpbcd_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  bpbcd_pkg::job_type           push_job,
   input  logic                         pop,
   output bpbcd_pkg::job_type           pop_job,
   output bpbcd_pkg::queue_status_type  q_status
);
   import bpbcd_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign q_status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign pop_job        = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[rtl/core/bpbcd_back.sv]
// Back end: double-dabble conversion, leading-zero removal and byte emission.
// Depends on bpbcd_pkg and bpbcd_if.
module bpbcd_back (
   input  logic                         clock,
   input  logic                         reset,
   input  bpbcd_pkg::queue_status_type  q_status,
   input  bpbcd_pkg::job_type           pop_job,
   output logic                         pop,
   bpbcd_rsp_if.source                  rsp
);
   import bpbcd_pkg::*;

   back_state_type      state_ff, state_in;
   logic [BCD_W-1:0]    bcd_ff, bcd_in;
   logic [VALUE_W-1:0]  mag_ff, mag_in;
   logic                neg_ff, neg_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [ND_W-1:0]     nd_ff, nd_in;
   logic                ok_ff, ok_in;
   logic [STREAM_W-1:0] stream_ff, stream_in;
   logic [LEN_W-1:0]    cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]   out_byte_ff, out_byte_in;
   logic                byte_valid_ff, byte_valid_in;
   logic                last_ff, last_in;
   logic                rsp_ok_ff, rsp_ok_in;
   logic                out_free;
   logic                is_last;
   logic [BCD_W-1:0]    bcd_adj;
   logic [LEN_W-1:0]    nbytes;

   assign out_free       = !rsp_valid_ff || rsp.ready;
   assign is_last        = (cnt_ff == len_ff - LEN_W'(1));
   assign bcd_adj        = dabble_adjust(bcd_ff);
   assign nbytes         = (LEN_W'(nd_ff) + LEN_W'(2)) >> 1;
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.out_byte   = out_byte_ff;
   assign rsp.byte_valid = byte_valid_ff;
   assign rsp.last       = last_ff;
   assign rsp.ok         = rsp_ok_ff;

   always_comb begin
      state_in      = state_ff;
      bcd_in        = bcd_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      len_in        = len_ff;
      step_in       = step_ff;
      nd_in         = nd_ff;
      ok_in         = ok_ff;
      stream_in     = stream_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      out_byte_in   = out_byte_ff;
      byte_valid_in = byte_valid_ff;
      last_in       = last_ff;
      rsp_ok_in     = rsp_ok_ff;
      pop           = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               pop    = 1'b1;
               neg_in = pop_job.neg;
               mag_in = pop_job.mag;
               len_in = pop_job.len;
               cnt_in = '0;
               unique case (pop_job.kind)
                  KIND_FAIL: begin
                     state_in = ST_FAIL;
                  end
                  KIND_ZERO: begin
                     stream_in = {ZERO_BYTE, {BCD_DIGITS{NIB_FILL}}};
                     ok_in     = 1'b1;
                     state_in  = ST_EMIT;
                  end
                  default: begin
                     bcd_in   = '0;
                     step_in  = '0;
                     state_in = ST_CONVERT;
                  end
               endcase
            end
         end
         ST_CONVERT: begin
            bcd_in  = {bcd_adj[BCD_W-2:0], mag_ff[VALUE_W-1]};
            mag_in  = mag_ff << 1;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(VALUE_W - 1)) begin
               nd_in    = ND_W'(BCD_DIGITS);
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            if (bcd_ff[BCD_W-1 -: NIB_W] == '0) begin
               bcd_in = {bcd_ff[BCD_W-NIB_W-1:0], NIB_FILL};
               nd_in  = nd_ff - ND_W'(1);
            end else begin
               stream_in = {(neg_ff ? NIB_NEG : NIB_POS), bcd_ff, NIB_FILL};
               ok_in     = (nbytes <= len_ff);
               state_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_byte_in   = stream_ff[STREAM_W-1 -: BYTE_W];
               byte_valid_in = 1'b1;
               last_in       = is_last;
               rsp_ok_in     = is_last && ok_ff;
               stream_in     = {stream_ff[STREAM_W-BYTE_W-1:0], PAD_BYTE};
               cnt_in        = cnt_ff + LEN_W'(1);
               if (is_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FAIL: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_byte_in   = '0;
               byte_valid_in = 1'b0;
               last_in       = 1'b1;
               rsp_ok_in     = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bcd_ff        <= bcd_in;
      mag_ff        <= mag_in;
      neg_ff        <= neg_in;
      len_ff        <= len_in;
      step_ff       <= step_in;
      nd_ff         <= nd_in;
      ok_ff         <= ok_in;
      stream_ff     <= stream_in;
      cnt_ff        <= cnt_in;
      out_byte_ff   <= out_byte_in;
      byte_valid_ff <= byte_valid_in;
      last_ff       <= last_in;
      rsp_ok_ff     <= rsp_ok_in;
   end

endmodule

[rtl/core/binary_to_packed_bcd.sv]
// Channel   Dir  Beat contents
// req_ch    in   value (32-bit signed), field_length (bytes, 5 bits)
// rsp_ch    out  out_byte, byte_valid, last, ok; field_length beats, or one on failure
//
// A request is registered in the front register, then waits in a two-entry queue.
// The back end loads a job, converts the magnitude by shift-and-add-3, removes leading
// zeros and emits the response beats in order; zero and failures skip conversion.
// Reset is synchronous and active high; it empties the queue and the response register.
// A stalled response holds the back end only; the front keeps taking requests until the
// queue and the front register are both full.
// Top level of the converter; depends on bpbcd_pkg, bpbcd_if, bpbcd_front, bpbcd_queue
// and bpbcd_back.
module binary_to_packed_bcd #(
   parameter int MAX_FIELD_BYTES = bpbcd_pkg::MAX_FIELD_BYTES_DEF
) (
   input logic         clock,
   input logic         reset,
   bpbcd_req_if.sink   req_ch,
   bpbcd_rsp_if.source rsp_ch
);
   import bpbcd_pkg::*;

   queue_status_type q_status;
   logic             push;
   logic             pop;
   job_type          push_job;
   job_type          pop_job;

   bpbcd_front #(
      .MAX_FIELD_BYTES(MAX_FIELD_BYTES)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .q_status(q_status),
      .push    (push),
      .push_job(push_job)
   );

   bpbcd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_job(push_job),
      .pop     (pop),
      .pop_job (pop_job),
      .q_status(q_status)
   );

   bpbcd_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_status(q_status),
      .pop_job (pop_job),
      .pop     (pop),
      .rsp     (rsp_ch)
   );

endmodule

[rtl/core/bpbcd_checker.sv]
// Port-level checks for the converter, attached to the top level by a bind.
// Depends on binary_to_packed_bcd and the channel interfaces.
module bpbcd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_byte_valid,
   input logic       rsp_last,
   input logic       rsp_ok
);

   // A beat that is held back keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) &&
      $stable(rsp_byte_valid) && $stable(rsp_last) && $stable(rsp_ok))
      else $error("response beat changed while stalled");

   a_ok_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ok |-> rsp_last && rsp_byte_valid)
      else $error("ok set away from the final written beat");

   a_fail_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_last && !rsp_ok && (rsp_out_byte == 8'h00))
      else $error("empty beat is not a lone failure");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

endmodule

bind binary_to_packed_bcd bpbcd_checker u_bpbcd_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_out_byte  (rsp_ch.out_byte),
   .rsp_byte_valid(rsp_ch.byte_valid),
   .rsp_last      (rsp_ch.last),
   .rsp_ok        (rsp_ch.ok)
);
